### src/rdt_pkg.sv
package rdt_pkg;

   localparam int TRACK_SLOTS_DEF = 64;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 22;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_REGION_LEFT   = 3'd0,
      REG_REGION_TOP    = 3'd1,
      REG_REGION_SPAN_X = 3'd2,
      REG_REGION_SPAN_Y = 3'd3,
      REG_DWELL_LIMIT   = 3'd4,
      REG_FRAME_COLS    = 3'd5,
      REG_FRAME_ROWS    = 3'd6
   } reg_index_type;

   localparam logic [15:0] RST_REGION_LEFT   = 16'd0;
   localparam logic [15:0] RST_REGION_TOP    = 16'd0;
   localparam logic [15:0] RST_REGION_SPAN_X = 16'hFFFF;
   localparam logic [15:0] RST_REGION_SPAN_Y = 16'hFFFF;
   localparam logic [21:0] RST_DWELL_LIMIT   = 22'd10000;
   localparam logic [12:0] RST_FRAME_COLS    = 13'd1920;
   localparam logic [12:0] RST_FRAME_ROWS    = 13'd1080;

   localparam logic [7:0] CLASS_CAR     = 8'd0;
   localparam logic [7:0] CLASS_TRUCK   = 8'd2;
   localparam logic [7:0] CLASS_BUS     = 8'd5;
   localparam logic [7:0] CLASS_VEHICLE = 8'd7;

   localparam int BLINK_SPAN_MS = 3000;
   localparam int BLINK_HALF_MS = 300;
   localparam int BLINK_STEPS   = BLINK_SPAN_MS / BLINK_HALF_MS;

   typedef enum logic [1:0] {
      PH_OUTSIDE = 2'd0,
      PH_INSIDE  = 2'd1,
      PH_ALERT   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      COL_GREEN  = 2'd0,
      COL_ORANGE = 2'd1,
      COL_PINK   = 2'd2
   } colour_type;

   localparam logic [2:0] BORDER_GREEN  = 3'd2;
   localparam logic [2:0] BORDER_ORANGE = 3'd3;
   localparam logic [2:0] BORDER_PINK   = 3'd4;

   typedef struct packed {
      logic [31:0] key;
      phase_type   phase;
      logic [31:0] entry_ms;
      logic [31:0] alert_ms;
   } slot_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SCAN   = 2'd1,
      ST_UPDATE = 2'd2
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic vehicle;
      logic hit;
      logic miss;
      logic out_free;
   } stat_type;

endpackage

### src/roi_dwell_time_alert_tracker_core.sv
// Vehicle dwell tracker for one rectangular region. Each request beat is one
// detection; each produces exactly one response beat with box colour, border,
// blink fill, event flags and running totals. Up to TRACK_SLOTS distinct
// tracks are kept; slots fill in order and are never released, so a lookup
// scans only the filled slots, one memory read per cycle, over the slot
// memory's single read port. An item is captured, then the filled slots are
// read until a key matches (the match shows in the cycle after its read) or
// all are read, then the slot is updated and the result registered;
// non-vehicle classes do not wait for the scan. A held response stalls the
// update, and no new request is taken until the result is registered.
// Register writes are accepted every cycle and must only be issued while the
// block is idle.
module roi_dwell_time_alert_tracker_core
   import rdt_pkg::*;
#(
   parameter int TRACK_SLOTS = TRACK_SLOTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // register port
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // request beats
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_class_code,
   input  logic [31:0]            req_track_key,
   input  logic [11:0]            req_box_left,
   input  logic [11:0]            req_box_top,
   input  logic [11:0]            req_box_cols,
   input  logic [11:0]            req_box_rows,
   input  logic [31:0]            req_now_ms,
   // response beats
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_box_colour,
   output logic [2:0]             rsp_border_px,
   output logic                   rsp_fill_on,
   output logic                   rsp_new_track,
   output logic                   rsp_alert_raised,
   output logic                   rsp_table_full,
   output logic [31:0]            rsp_detected_total,
   output logic [31:0]            rsp_alert_total,
   output logic                   rsp_region_occupied_seen,
   output logic                   rsp_region_alert_seen
);

   cmd_type  cmd;
   stat_type stat;

   // registers never back-pressure
   assign csr_ready = 1'b1;

   rdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rdt_datapath #(
      .TRACK_SLOTS (TRACK_SLOTS)
   ) u_datapath (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .stat                     (stat),
      .csr_valid                (csr_valid),
      .csr_index                (csr_index),
      .csr_wdata                (csr_wdata),
      .req_class_code           (req_class_code),
      .req_track_key            (req_track_key),
      .req_box_left             (req_box_left),
      .req_box_top              (req_box_top),
      .req_box_cols             (req_box_cols),
      .req_box_rows             (req_box_rows),
      .req_now_ms               (req_now_ms),
      .rsp_stall                (rsp_stall),
      .rsp_valid                (rsp_valid),
      .rsp_box_colour           (rsp_box_colour),
      .rsp_border_px            (rsp_border_px),
      .rsp_fill_on              (rsp_fill_on),
      .rsp_new_track            (rsp_new_track),
      .rsp_alert_raised         (rsp_alert_raised),
      .rsp_table_full           (rsp_table_full),
      .rsp_detected_total       (rsp_detected_total),
      .rsp_alert_total          (rsp_alert_total),
      .rsp_region_occupied_seen (rsp_region_occupied_seen),
      .rsp_region_alert_seen    (rsp_region_alert_seen)
   );

endmodule

### src/rdt_ctrl.sv
module rdt_ctrl
   import rdt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (!stat.vehicle || stat.hit || stat.miss) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

### src/rdt_datapath.sv
module rdt_datapath
   import rdt_pkg::*;
#(
   parameter int TRACK_SLOTS = TRACK_SLOTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [7:0]             req_class_code,
   input  logic [31:0]            req_track_key,
   input  logic [11:0]            req_box_left,
   input  logic [11:0]            req_box_top,
   input  logic [11:0]            req_box_cols,
   input  logic [11:0]            req_box_rows,
   input  logic [31:0]            req_now_ms,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_box_colour,
   output logic [2:0]             rsp_border_px,
   output logic                   rsp_fill_on,
   output logic                   rsp_new_track,
   output logic                   rsp_alert_raised,
   output logic                   rsp_table_full,
   output logic [31:0]            rsp_detected_total,
   output logic [31:0]            rsp_alert_total,
   output logic                   rsp_region_occupied_seen,
   output logic                   rsp_region_alert_seen
);

   localparam int IW = $clog2(TRACK_SLOTS);
   localparam int CW = $clog2(TRACK_SLOTS + 1);

   // config registers
   logic [15:0] left_ff, top_ff, span_x_ff, span_y_ff;
   logic [21:0] dwell_ff;
   logic [12:0] cols_ff, rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= RST_REGION_LEFT;
         top_ff    <= RST_REGION_TOP;
         span_x_ff <= RST_REGION_SPAN_X;
         span_y_ff <= RST_REGION_SPAN_Y;
         dwell_ff  <= RST_DWELL_LIMIT;
         cols_ff   <= RST_FRAME_COLS;
         rows_ff   <= RST_FRAME_ROWS;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_REGION_LEFT:   left_ff   <= csr_wdata[15:0];
            REG_REGION_TOP:    top_ff    <= csr_wdata[15:0];
            REG_REGION_SPAN_X: span_x_ff <= csr_wdata[15:0];
            REG_REGION_SPAN_Y: span_y_ff <= csr_wdata[15:0];
            REG_DWELL_LIMIT:   dwell_ff  <= csr_wdata;
            REG_FRAME_COLS:    cols_ff   <= csr_wdata[12:0];
            REG_FRAME_ROWS:    rows_ff   <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // captured item
   logic [7:0]  cls_ff;
   logic [31:0] key_ff, now_ff;
   logic [11:0] bl_ff, bt_ff, bc_ff, br_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cls_ff <= req_class_code;
         key_ff <= req_track_key;
         bl_ff  <= req_box_left;
         bt_ff  <= req_box_top;
         bc_ff  <= req_box_cols;
         br_ff  <= req_box_rows;
         now_ff <= req_now_ms;
      end
   end

   // region test: centre*65536*2*frame bounds, cross multiplied
   logic [13:0] cen_x, cen_y, den_x, den_y;
   logic [29:0] lo_x_ff, lo_y_ff;
   logic [30:0] hi_x_ff, hi_y_ff;
   logic        in_region;

   assign cen_x = {1'b0, bl_ff, 1'b0} + {2'b00, bc_ff};
   assign cen_y = {1'b0, bt_ff, 1'b0} + {2'b00, br_ff};
   assign den_x = {cols_ff, 1'b0};
   assign den_y = {rows_ff, 1'b0};

   always_ff @(posedge clock) begin
      lo_x_ff <= 30'(left_ff) * 30'(den_x);
      lo_y_ff <= 30'(top_ff) * 30'(den_y);
      hi_x_ff <= (31'(left_ff) + 31'(span_x_ff)) * 31'(den_x);
      hi_y_ff <= (31'(top_ff) + 31'(span_y_ff)) * 31'(den_y);
   end

   assign in_region = ({cen_x, 16'h0} >= lo_x_ff) && ({1'b0, cen_x, 16'h0} <= hi_x_ff)
                   && ({cen_y, 16'h0} >= lo_y_ff) && ({1'b0, cen_y, 16'h0} <= hi_y_ff);

   // slot table, filled in order, scanned one entry a cycle
   slot_type       mem [TRACK_SLOTS];
   slot_type       q_ff;
   logic [IW-1:0]  q_idx_ff;
   logic           q_vld_ff;
   logic [CW-1:0]  rd_idx_ff;
   logic [CW-1:0]  count_ff;
   logic           hit, issue;

   assign hit   = q_vld_ff && (q_ff.key == key_ff);
   assign issue = cmd.scan && !hit && (rd_idx_ff < count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         q_vld_ff  <= 1'b0;
         rd_idx_ff <= '0;
      end else if (cmd.load) begin
         q_vld_ff  <= 1'b0;
         rd_idx_ff <= '0;
      end else if (cmd.scan && !hit) begin
         q_vld_ff  <= issue;
         rd_idx_ff <= issue ? rd_idx_ff + 1'b1 : rd_idx_ff;
      end
   end

   logic          vehicle, new_slot, have_slot, we;
   logic [IW-1:0] wr_idx;
   slot_type      wdata;

   always_ff @(posedge clock) begin
      if (issue) begin
         q_ff     <= mem[rd_idx_ff[IW-1:0]];
         q_idx_ff <= rd_idx_ff[IW-1:0];
      end
      if (we) begin
         mem[wr_idx] <= wdata;
      end
   end

   assign vehicle   = (cls_ff == CLASS_CAR) || (cls_ff == CLASS_TRUCK)
                   || (cls_ff == CLASS_BUS) || (cls_ff == CLASS_VEHICLE);
   assign new_slot  = !hit && (count_ff < CW'(TRACK_SLOTS));
   assign have_slot = hit || new_slot;
   assign wr_idx    = hit ? q_idx_ff : count_ff[IW-1:0];
   assign we        = cmd.commit && vehicle && have_slot;

   // per-item decision
   phase_type   ph_old;
   logic [31:0] entry_old, alert_old, dwell_t, blink_t;
   logic        raised, occ, alerted, fill, parity;
   colour_type  colour;
   logic [2:0]  border;

   always_comb begin
      ph_old    = new_slot ? PH_OUTSIDE : q_ff.phase;
      entry_old = new_slot ? 32'd0 : q_ff.entry_ms;
      alert_old = new_slot ? 32'd0 : q_ff.alert_ms;
      dwell_t   = now_ff - entry_old;
      wdata.key      = key_ff;
      wdata.phase    = ph_old;
      wdata.entry_ms = entry_old;
      wdata.alert_ms = alert_old;
      raised  = 1'b0;
      occ     = 1'b0;
      alerted = 1'b0;
      fill    = 1'b0;
      colour  = COL_GREEN;
      border  = BORDER_GREEN;
      parity  = 1'b0;
      blink_t = '0;
      if (vehicle) begin
         if (!have_slot) begin
            if (in_region) begin
               occ    = 1'b1;
               colour = COL_ORANGE;
               border = BORDER_ORANGE;
            end
         end else if (in_region) begin
            occ = 1'b1;
            unique case (ph_old)
               PH_ALERT: ;
               PH_INSIDE: begin
                  if (dwell_t >= 32'(dwell_ff)) begin
                     wdata.phase    = PH_ALERT;
                     wdata.alert_ms = now_ff;
                     raised         = 1'b1;
                  end
               end
               default: begin
                  wdata.phase    = PH_INSIDE;
                  wdata.entry_ms = now_ff;
               end
            endcase
            if (wdata.phase == PH_ALERT) begin
               blink_t = now_ff - wdata.alert_ms;
               for (int k = 1; k < BLINK_STEPS; k++) begin
                  parity = parity ^ (blink_t[11:0] >= 12'(k * BLINK_HALF_MS));
               end
               alerted = 1'b1;
               colour  = COL_PINK;
               border  = BORDER_PINK;
               fill    = (blink_t < 32'(BLINK_SPAN_MS)) && !parity;
            end else begin
               colour = COL_ORANGE;
               border = BORDER_ORANGE;
            end
         end else begin
            wdata.phase = PH_OUTSIDE;
         end
      end
   end

   // counters, sticky flags and result register
   logic [31:0] det_ff, alr_ff;
   logic        occ_ff, alerted_ff, rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         det_ff       <= '0;
         alr_ff       <= '0;
         occ_ff       <= 1'b0;
         alerted_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.commit && vehicle) begin
            if (new_slot) begin
               count_ff <= count_ff + 1'b1;
               if (det_ff != '1) det_ff <= det_ff + 1'b1;
            end
            if (raised && alr_ff != '1) alr_ff <= alr_ff + 1'b1;
            if (occ) occ_ff <= 1'b1;
            if (alerted) alerted_ff <= 1'b1;
         end
      end
   end

   logic        r_new_ff, r_raised_ff, r_full_ff, r_fill_ff;
   colour_type  r_colour_ff;
   logic [2:0]  r_border_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         r_colour_ff <= colour;
         r_border_ff <= border;
         r_fill_ff   <= fill;
         r_new_ff    <= vehicle && new_slot;
         r_raised_ff <= raised;
         r_full_ff   <= vehicle && !have_slot;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_box_colour           = r_colour_ff;
   assign rsp_border_px            = r_border_ff;
   assign rsp_fill_on              = r_fill_ff;
   assign rsp_new_track            = r_new_ff;
   assign rsp_alert_raised         = r_raised_ff;
   assign rsp_table_full           = r_full_ff;
   assign rsp_detected_total       = det_ff;
   assign rsp_alert_total          = alr_ff;
   assign rsp_region_occupied_seen = occ_ff;
   assign rsp_region_alert_seen    = alerted_ff;

   assign stat.vehicle  = vehicle;
   assign stat.hit      = hit;
   assign stat.miss     = !q_vld_ff && (rd_idx_ff >= count_ff);
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TRACK_SLOTS))
      else $error("slot fill count beyond table size");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && vehicle && new_slot |=> count_ff == $past(count_ff) + 1'b1)
      else $error("new track did not take the next slot");

   a_raise_pink: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && r_raised_ff |-> r_colour_ff == COL_PINK && r_fill_ff)
      else $error("raised alert not drawn pink with fill");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !rsp_valid_ff || !rsp_stall)
      else $error("result overwritten while held");

endmodule

### verif/tb_roi_dwell_time_alert_tracker_core.sv
`timescale 1ns / 1ps

module tb_roi_dwell_time_alert_tracker_core
   import rdt_pkg::*;
;

   localparam int SLOTS     = TRACK_SLOTS_DEF;
   localparam int MAX_CYC   = 3_000_000;
   localparam int IDLE_WAIT = 200;

   typedef struct {
      logic [7:0]  class_code;
      logic [31:0] track_key;
      logic [11:0] box_left;
      logic [11:0] box_top;
      logic [11:0] box_cols;
      logic [11:0] box_rows;
      logic [31:0] now_ms;
   } detection_type;

   typedef struct {
      logic [1:0]  box_colour;
      logic [2:0]  border_px;
      logic        fill_on;
      logic        fresh_track;
      logic        alert_raised;
      logic        table_full;
      logic [31:0] detected_total;
      logic [31:0] alert_total;
      logic        occupied_seen;
      logic        alert_seen;
   } verdict_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic req_valid = 0;
   logic req_stall;
   logic [7:0]  req_class_code = '0;
   logic [31:0] req_track_key = '0;
   logic [11:0] req_box_left = '0, req_box_top = '0, req_box_cols = '0, req_box_rows = '0;
   logic [31:0] req_now_ms = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [1:0]  rsp_box_colour;
   logic [2:0]  rsp_border_px;
   logic rsp_fill_on, rsp_new_track, rsp_alert_raised, rsp_table_full;
   logic [31:0] rsp_detected_total, rsp_alert_total;
   logic rsp_region_occupied_seen, rsp_region_alert_seen;

   roi_dwell_time_alert_tracker_core dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // local copy of the configuration and track table
   logic [15:0] m_left, m_top, m_span_x, m_span_y;
   logic [21:0] m_dwell;
   logic [12:0] m_cols, m_rows;
   logic        m_valid [SLOTS];
   logic [31:0] m_key [SLOTS];
   phase_type   m_phase [SLOTS];
   logic [31:0] m_entry [SLOTS];
   logic [31:0] m_alert [SLOTS];
   logic [31:0] m_detected, m_alerts;
   logic        m_occupied, m_alerted;

   detection_type pending_beats[$];
   verdict_type   awaited_verdicts[$];
   int  errors = 0;
   int  send_idle_pct = 0, recv_idle_pct = 0;
   int  hold_off_cycles = 0;  // receiver long stall, counted in its own process
   bit  hold_off_req = 0;
   longint cycles = 0;

   // stall as sampled at the last rising edge: decides if the held beat was taken
   logic req_stall_s = 0;

   function automatic bit axis_hit(logic [11:0] start, logic [11:0] len, logic [12:0] frame,
                                   logic [15:0] edge_pos, logic [15:0] span);
      logic [63:0] num, den;
      num = ({52'd0, start} * 2 + len) * 65536;
      den = {51'd0, frame} * 2;
      return num >= edge_pos * den && num <= ({48'd0, edge_pos} + span) * den;
   endfunction

   function automatic logic [31:0] bump(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 1;
   endfunction

   function automatic verdict_type track_detection(detection_type d);
      verdict_type v;
      bit hit_in, veh_class;
      int slot, free_slot;
      logic [31:0] t;
      v = '{box_colour: COL_GREEN, border_px: BORDER_GREEN, default: '0};
      veh_class = d.class_code == CLASS_CAR || d.class_code == CLASS_TRUCK ||
                  d.class_code == CLASS_BUS || d.class_code == CLASS_VEHICLE;
      if (veh_class) begin
         hit_in = axis_hit(d.box_left, d.box_cols, m_cols, m_left, m_span_x) &&
                  axis_hit(d.box_top, d.box_rows, m_rows, m_top, m_span_y);
         slot = -1;
         free_slot = -1;
         for (int i = 0; i < SLOTS; i++) begin
            if (m_valid[i]) begin
               if (slot < 0 && m_key[i] == d.track_key) slot = i;
            end else if (free_slot < 0) free_slot = i;
         end
         if (slot < 0 && free_slot >= 0) begin
            slot = free_slot;
            m_valid[slot] = 1;
            m_key[slot] = d.track_key;
            m_phase[slot] = PH_OUTSIDE;
            m_entry[slot] = 0;
            m_alert[slot] = 0;
            m_detected = bump(m_detected);
            v.fresh_track = 1;
         end
         if (slot < 0) begin
            v.table_full = 1;
            if (hit_in) begin
               m_occupied = 1;
               v.box_colour = COL_ORANGE;
               v.border_px = BORDER_ORANGE;
            end
         end else if (hit_in) begin
            m_occupied = 1;
            if (m_phase[slot] == PH_INSIDE) begin
               if (d.now_ms - m_entry[slot] >= {10'd0, m_dwell}) begin
                  m_phase[slot] = PH_ALERT;
                  m_alert[slot] = d.now_ms;
                  m_alerts = bump(m_alerts);
                  v.alert_raised = 1;
               end
            end else if (m_phase[slot] != PH_ALERT) begin
               m_phase[slot] = PH_INSIDE;
               m_entry[slot] = d.now_ms;
            end
            if (m_phase[slot] == PH_ALERT) begin
               t = d.now_ms - m_alert[slot];
               m_alerted = 1;
               v.box_colour = COL_PINK;
               v.border_px = BORDER_PINK;
               v.fill_on = t < BLINK_SPAN_MS && ((t / BLINK_HALF_MS) % 2) == 0;
            end else begin
               v.box_colour = COL_ORANGE;
               v.border_px = BORDER_ORANGE;
            end
         end else m_phase[slot] = PH_OUTSIDE;
      end
      v.detected_total = m_detected;
      v.alert_total = m_alerts;
      v.occupied_seen = m_occupied;
      v.alert_seen = m_alerted;
      return v;
   endfunction

   // feeder: one beat offered at a time, payload held while stalled
   always @(negedge clock) begin
      if (!reset) begin
         if (!(req_valid && req_stall_s)) begin
            if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1;
               req_class_code <= pending_beats[0].class_code;
               req_track_key <= pending_beats[0].track_key;
               req_box_left <= pending_beats[0].box_left;
               req_box_top <= pending_beats[0].box_top;
               req_box_cols <= pending_beats[0].box_cols;
               req_box_rows <= pending_beats[0].box_rows;
               req_now_ms <= pending_beats[0].now_ms;
               void'(pending_beats.pop_front());
            end else req_valid <= 0;
         end
      end
   end

   // response stall, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_off_req && hold_off_cycles == 0) hold_off_cycles = 400;
      if (hold_off_cycles > 0) begin
         hold_off_cycles = hold_off_cycles - 1;
         if (hold_off_cycles == 0) hold_off_req = 0;
         rsp_stall <= 1;
      end else rsp_stall <= !reset && $urandom_range(99) < recv_idle_pct;
   end

   // monitor: request acceptance drives prediction, responses are checked
   always @(posedge clock) begin
      verdict_type e;
      detection_type d;
      cycles <= cycles + 1;
      req_stall_s <= !reset && req_valid && req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            d.class_code = req_class_code;
            d.track_key = req_track_key;
            d.box_left = req_box_left;
            d.box_top = req_box_top;
            d.box_cols = req_box_cols;
            d.box_rows = req_box_rows;
            d.now_ms = req_now_ms;
            awaited_verdicts.push_back(track_detection(d));
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_verdicts.size() == 0) begin
               $error("response with nothing expected");
               errors++;
            end else begin
               e = awaited_verdicts.pop_front();
               if (rsp_box_colour !== e.box_colour) begin
                  $error("box_colour exp %0d got %0d", e.box_colour, rsp_box_colour); errors++;
               end
               if (rsp_border_px !== e.border_px) begin
                  $error("border_px exp %0d got %0d", e.border_px, rsp_border_px); errors++;
               end
               if (rsp_fill_on !== e.fill_on) begin
                  $error("fill_on exp %0d got %0d", e.fill_on, rsp_fill_on); errors++;
               end
               if (rsp_new_track !== e.fresh_track) begin
                  $error("rsp_new_track exp %0d got %0d", e.fresh_track, rsp_new_track);
                  errors++;
               end
               if (rsp_alert_raised !== e.alert_raised) begin
                  $error("alert_raised exp %0d got %0d", e.alert_raised, rsp_alert_raised);
                  errors++;
               end
               if (rsp_table_full !== e.table_full) begin
                  $error("table_full exp %0d got %0d", e.table_full, rsp_table_full); errors++;
               end
               if (rsp_detected_total !== e.detected_total) begin
                  $error("detected_total exp %0d got %0d", e.detected_total,
                         rsp_detected_total);
                  errors++;
               end
               if (rsp_alert_total !== e.alert_total) begin
                  $error("alert_total exp %0d got %0d", e.alert_total, rsp_alert_total);
                  errors++;
               end
               if (rsp_region_occupied_seen !== e.occupied_seen) begin
                  $error("region_occupied_seen exp %0d got %0d", e.occupied_seen,
                         rsp_region_occupied_seen);
                  errors++;
               end
               if (rsp_region_alert_seen !== e.alert_seen) begin
                  $error("region_alert_seen exp %0d got %0d", e.alert_seen,
                         rsp_region_alert_seen);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > MAX_CYC) begin
         $display("simulation failed");
         $finish;
      end
   end

   // wait until every queued beat is taken and every response has come back
   task automatic drain();
      while (pending_beats.size() > 0 || req_valid || awaited_verdicts.size() > 0)
         @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [21:0] value);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_REGION_LEFT:   m_left = value[15:0];
         REG_REGION_TOP:    m_top = value[15:0];
         REG_REGION_SPAN_X: m_span_x = value[15:0];
         REG_REGION_SPAN_Y: m_span_y = value[15:0];
         REG_DWELL_LIMIT:   m_dwell = value;
         REG_FRAME_COLS:    m_cols = value[12:0];
         REG_FRAME_ROWS:    m_rows = value[12:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic push(logic [7:0] cls, logic [31:0] key, logic [11:0] bl, logic [11:0] bt,
                       logic [11:0] bc, logic [11:0] br, logic [31:0] now);
      detection_type d;
      d = '{cls, key, bl, bt, bc, br, now};
      pending_beats.push_back(d);
   endtask

   function automatic logic [7:0] pick_class();
      case ($urandom_range(9))
         0, 1: return CLASS_CAR;
         2, 3: return CLASS_TRUCK;
         4, 5: return CLASS_BUS;
         6, 7: return CLASS_VEHICLE;
         default: return 8'($urandom);
      endcase
   endfunction

   // realistic dwell sessions: a small set of keys loiter with rising time
   task automatic random_phase(int n, int key_pool, logic [31:0] key_base);
      logic [31:0] clock_ms;
      clock_ms = $urandom;
      for (int i = 0; i < n; i++) begin
         clock_ms += $urandom_range(1, 400) * (($urandom_range(19) == 0) ? 50 : 1);
         if ($urandom_range(15) == 0)
            push(8'($urandom), $urandom, 12'($urandom), 12'($urandom), 12'($urandom),
                 12'($urandom), $urandom);
         else
            push(pick_class(), key_base + $urandom_range(key_pool - 1),
                 12'($urandom_range(0, 1900)), 12'($urandom_range(0, 1070)),
                 12'($urandom_range(0, 200)), 12'($urandom_range(0, 200)), clock_ms);
      end
   endtask

   initial begin
      m_left = RST_REGION_LEFT;
      m_top = RST_REGION_TOP;
      m_span_x = RST_REGION_SPAN_X;
      m_span_y = RST_REGION_SPAN_Y;
      m_dwell = RST_DWELL_LIMIT;
      m_cols = RST_FRAME_COLS;
      m_rows = RST_FRAME_ROWS;
      for (int i = 0; i < SLOTS; i++) m_valid[i] = 0;
      m_detected = 0;
      m_alerts = 0;
      m_occupied = 0;
      m_alerted = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: non-vehicles, each vehicle class, dwell then alert and blink
      push(8'd1, 32'hFFFF_FFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
      push(8'hFF, 0, 0, 0, 0, 0, 0);
      push(CLASS_CAR, 32'd10, 12'd900, 12'd500, 12'd100, 12'd60, 32'd1000);
      push(CLASS_CAR, 32'd10, 12'd900, 12'd500, 12'd100, 12'd60, 32'd10999);
      push(CLASS_CAR, 32'd10, 12'd900, 12'd500, 12'd100, 12'd60, 32'd11000);  // alert
      push(CLASS_CAR, 32'd10, 12'd900, 12'd500, 12'd100, 12'd60, 32'd11299);
      push(CLASS_CAR, 32'd10, 12'd900, 12'd500, 12'd100, 12'd60, 32'd11300);
      push(CLASS_CAR, 32'd10, 12'd900, 12'd500, 12'd100, 12'd60, 32'd13999);
      push(CLASS_CAR, 32'd10, 12'd900, 12'd500, 12'd100, 12'd60, 32'd14000);
      push(CLASS_TRUCK, 32'hFFFF_FFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 32'hFFFF_FF00);
      push(CLASS_BUS, 32'd0, 0, 0, 0, 0, 32'hFFFF_FFF0);
      push(CLASS_BUS, 32'd0, 0, 0, 0, 0, 32'd9000);  // elapsed wraps past zero
      push(CLASS_VEHICLE, 32'd10, 12'd4000, 12'd500, 12'd90, 12'd60, 32'd20000);
      drain();

      // tight region, zero dwell, tiny frame: bounds and instant alerts
      write_reg(REG_REGION_LEFT, 22'd32768);
      write_reg(REG_REGION_TOP, 22'd32768);
      write_reg(REG_REGION_SPAN_X, 22'd0);
      write_reg(REG_REGION_SPAN_Y, 22'd0);
      write_reg(REG_DWELL_LIMIT, 22'd0);
      write_reg(REG_FRAME_COLS, 22'd4);
      write_reg(REG_FRAME_ROWS, 22'd2);
      push(CLASS_CAR, 32'd77, 12'd1, 12'd0, 12'd2, 12'd2, 32'd5);  // centre on both edges
      push(CLASS_CAR, 32'd77, 12'd1, 12'd0, 12'd2, 12'd2, 32'd5);
      push(CLASS_CAR, 32'd78, 12'd1, 12'd0, 12'd3, 12'd2, 32'd5);
      drain();

      // zero frame size, then a long dwell limit reached exactly
      write_reg(REG_FRAME_COLS, 22'h2000);  // writes 0 after truncation to 13 bits
      write_reg(REG_FRAME_ROWS, 22'd0);
      write_reg(REG_REGION_LEFT, 22'd0);
      write_reg(REG_REGION_TOP, 22'd0);
      push(CLASS_CAR, 32'd90, 0, 0, 0, 0, 32'd1);
      push(CLASS_CAR, 32'd91, 12'd1, 0, 0, 0, 32'd1);
      drain();
      write_reg(REG_DWELL_LIMIT, 22'd3600000);
      write_reg(REG_FRAME_COLS, 22'd4096);
      write_reg(REG_FRAME_ROWS, 22'd4096);
      write_reg(REG_REGION_SPAN_X, 22'hFFFF);
      write_reg(REG_REGION_SPAN_Y, 22'hFFFF);
      push(CLASS_TRUCK, 32'd92, 0, 0, 12'd10, 12'd10, 32'd0);
      push(CLASS_TRUCK, 32'd92, 0, 0, 12'd10, 12'd10, 32'd3600000);
      drain();

      // random phase 1: sender idles 29%, receiver 45%, mid-size region
      send_idle_pct = 29;
      recv_idle_pct = 45;
      write_reg(REG_REGION_LEFT, 22'd16384);
      write_reg(REG_REGION_TOP, 22'd16384);
      write_reg(REG_REGION_SPAN_X, 22'd32768);
      write_reg(REG_REGION_SPAN_Y, 22'd32768);
      write_reg(REG_DWELL_LIMIT, 22'd2000);
      write_reg(REG_FRAME_COLS, 22'd1920);
      write_reg(REG_FRAME_ROWS, 22'd1080);
      random_phase(150, 12, 32'h1000);
      hold_off_req = 1;  // long receiver stall while beats keep coming
      random_phase(170, 12, 32'h2000);
      drain();

      // phase 2: swapped idling, short dwell, more keys to fill the table
      send_idle_pct = 45;
      recv_idle_pct = 29;
      write_reg(REG_DWELL_LIMIT, 22'd500);
      random_phase(320, 40, 32'h3000);
      drain();

      // phase 3: no idling, fills the table and beyond
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(REG_REGION_LEFT, 22'd0);
      write_reg(REG_REGION_TOP, 22'd0);
      write_reg(REG_REGION_SPAN_X, 22'hFFFF);
      write_reg(REG_REGION_SPAN_Y, 22'hFFFF);
      write_reg(REG_DWELL_LIMIT, 22'd1000);
      random_phase(300, 60, 32'h4000);
      drain();

      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
